FILE: rtl/pnu_pkg.sv
// Shared types and constants of the normalized perceptron update unit.
`default_nettype none
package pnu_pkg;
    localparam int DIM_DEFAULT = 8;
    localparam int FEAT_W      = 16;
    localparam int WGT_W       = 32;

    // vector word handed from front to back
    typedef struct packed {
        logic learn;
        logic label;
    } t_job;

    typedef enum logic [3:0] {
        S_IDLE, S_DOT, S_DOTW, S_PRED, S_SQRT, S_DIVLD, S_DIV, S_UPD, S_OUT
    } t_state;
endpackage
`default_nettype wire

FILE: rtl/pnu_front.sv
// Front end: collects vector elements into a double buffer and queues closed vectors.
`default_nettype none
module pnu_front #(
    parameter int DIM = pnu_pkg::DIM_DEFAULT
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    output logic                            o_full,
    input  wire logic                       i_req_type,
    input  wire logic signed [15:0]         i_feature,
    input  wire logic                       i_label,
    input  wire logic                       i_last,
    // job queue toward back end
    output logic                            o_job_valid,
    output pnu_pkg::t_job                   o_job,
    output logic [$clog2(DIM+1)-1:0]        o_job_n,
    output logic                            o_job_bank,
    input  wire logic                       i_job_done,
    // buffer read port
    input  wire logic [(($clog2(DIM) > 0) ? $clog2(DIM) : 1)-1:0] i_rd_idx,
    input  wire logic                       i_rd_bank,
    output logic signed [15:0]              o_rd_data
);
    localparam int CW = $clog2(DIM+1);
    localparam int IW = ($clog2(DIM) > 0) ? $clog2(DIM) : 1;

    // bank bit on top of the element index
    logic signed [15:0] r_buf [2**(IW+1)];
    logic [CW-1:0]      r_cnt, n_cnt;
    logic               r_wbank;
    // two-entry queue of closed vectors, one per bank
    logic [1:0]         r_qv;
    pnu_pkg::t_job      r_qjob [2];
    logic [CW-1:0]      r_qn [2];
    logic               r_head;
    logic               accept;

    assign o_full = r_qv[r_wbank];
    assign accept = i_push && !o_full;
    assign n_cnt  = (r_cnt < CW'(DIM)) ? r_cnt + CW'(1) : r_cnt;

    always_ff @(posedge i_clk) begin
        if (accept && r_cnt < CW'(DIM)) begin
            r_buf[{r_wbank, r_cnt[IW-1:0]}] <= i_feature;
        end
        o_rd_data <= r_buf[{i_rd_bank, i_rd_idx}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_wbank <= 1'b0;
            r_qv    <= '0;
            r_head  <= 1'b0;
        end else begin
            if (i_job_done) begin
                r_qv[r_head] <= 1'b0;
                r_head       <= ~r_head;
            end
            if (accept) begin
                if (i_last) begin
                    r_qv[r_wbank]   <= 1'b1;
                    r_qjob[r_wbank] <= '{learn: i_req_type, label: i_label};
                    r_qn[r_wbank]   <= n_cnt;
                    r_cnt           <= '0;
                    r_wbank         <= ~r_wbank;
                end else begin
                    r_cnt <= n_cnt;
                end
            end
        end
    end

    assign o_job_valid = r_qv[r_head];
    assign o_job       = r_qjob[r_head];
    assign o_job_n     = r_qn[r_head];
    assign o_job_bank  = r_head;
endmodule
`default_nettype wire

FILE: rtl/pnu_back.sv
// Back end: dot product, square root, per-element division and weight update.
`default_nettype none
module pnu_back #(
    parameter int DIM = pnu_pkg::DIM_DEFAULT
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_job_valid,
    input  wire pnu_pkg::t_job              i_job,
    input  wire logic [$clog2(DIM+1)-1:0]   i_job_n,
    input  wire logic                       i_job_bank,
    output logic                            o_job_done,
    output logic [(($clog2(DIM) > 0) ? $clog2(DIM) : 1)-1:0] o_rd_idx,
    output logic                            o_rd_bank,
    input  wire logic signed [15:0]         i_rd_data,
    output logic                            o_empty,
    input  wire logic                       i_pop,
    output logic                            o_prediction,
    output logic                            o_updated,
    output logic                            o_saturated
);
    localparam int CW = $clog2(DIM+1);
    localparam int IW = ($clog2(DIM) > 0) ? $clog2(DIM) : 1;
    localparam int SW = 36;   // sum of up to 63 squares of 2^30
    localparam int AW = 54;   // exact dot product
    localparam int RW = 32;   // root of S*2^28 < 2^64
    localparam int WGT_W_L = pnu_pkg::WGT_W;

    pnu_pkg::t_state r_st, n_st;
    logic signed [WGT_W_L-1:0] r_w [DIM];

    logic [CW-1:0]          r_i;      // element index being read
    logic [CW-1:0]          r_n;
    logic                   r_learn, r_label, r_bank;
    logic signed [AW-1:0]   r_acc;
    logic [SW-1:0]          r_ss;
    logic signed [47:0]     r_prod;
    logic [31:0]            r_sq;
    logic                   r_pv, r_pv2;
    logic [CW-1:0]          r_pi;
    logic [CW-1:0]          r_pi_d;
    logic                   r_pred, r_sat;
    // square root
    logic [61:0]            r_rem;
    logic [RW-1:0]          r_root;
    logic [5:0]             r_sk;
    logic [63:0]            r_s;
    // division
    logic [47:0]            r_num;
    logic [RW-1:0]          r_drem;
    logic [5:0]             r_dk;
    logic [47:0]            r_q;
    logic                   r_neg;
    // output register
    logic                   r_ov, r_opred, r_oupd, r_osat;

    logic                   fetch;
    logic [IW-1:0]          widx;

    assign o_rd_bank = r_bank;
    assign o_rd_idx  = r_i[IW-1:0];
    assign widx      = r_pi[IW-1:0];

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            pnu_pkg::S_IDLE:  if (i_job_valid) n_st = pnu_pkg::S_DOT;
            pnu_pkg::S_DOT:   if (r_i == r_n) n_st = pnu_pkg::S_DOTW;
            pnu_pkg::S_DOTW:  if (!r_pv) n_st = pnu_pkg::S_PRED;
            pnu_pkg::S_PRED:  begin
                if (r_learn && (r_acc >= 0) != r_label && r_ss != '0)
                    n_st = pnu_pkg::S_SQRT;
                else
                    n_st = pnu_pkg::S_OUT;
            end
            pnu_pkg::S_SQRT:  if (r_sk == 6'd0) n_st = pnu_pkg::S_DIVLD;
            pnu_pkg::S_DIVLD: n_st = pnu_pkg::S_DIV;
            pnu_pkg::S_DIV:   if (r_dk == 6'd0) n_st = pnu_pkg::S_UPD;
            pnu_pkg::S_UPD:   n_st = (r_pi + CW'(1) == r_n) ? pnu_pkg::S_OUT
                                                             : pnu_pkg::S_DIVLD;
            pnu_pkg::S_OUT:   if (!r_ov) n_st = pnu_pkg::S_IDLE;
            default:          n_st = pnu_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        fetch      = (r_st == pnu_pkg::S_DOT) && (r_i != r_n);
        o_job_done = (r_st == pnu_pkg::S_OUT) && !r_ov;
    end

    logic [RW:0] dtrial;
    logic [RW+1:0] rtrial;
    logic signed [33:0] wsum;
    logic signed [17:0] nel;
    logic [16:0] qc;

    always_comb begin
        qc   = (r_q > 48'd65536) ? 17'd65536 : r_q[16:0];
        nel  = r_neg ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
        wsum = r_label ? 34'(r_w[widx]) + 34'(nel) : 34'(r_w[widx]) - 34'(nel);
    end

    // restoring sqrt and division trials: one result bit per cycle
    logic [63:0] srem_sh;
    logic [33:0] stry;
    always_comb begin
        srem_sh = {r_rem, r_s[63:62]};
        stry    = {r_root, 2'b01};
        dtrial  = {r_drem, r_num[47]};
        rtrial  = {1'b0, dtrial} - {2'b0, r_root};
    end

    logic [63:0] s_src;
    assign s_src = {r_ss[35:0], 28'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= pnu_pkg::S_IDLE;
            r_ov  <= 1'b0;
            r_pv  <= 1'b0;
            r_pv2 <= 1'b0;
            for (int k = 0; k < DIM; k++) r_w[k] <= '0;
        end else begin
            r_st  <= n_st;
            if (r_ov && i_pop) r_ov <= 1'b0;
            r_pv  <= fetch;
            r_pv2 <= r_pv;
            unique case (r_st)
                pnu_pkg::S_IDLE: begin
                    r_i     <= '0;
                    r_n     <= i_job_n;
                    r_learn <= i_job.learn;
                    r_label <= i_job.label;
                    r_bank  <= i_job_bank;
                    r_acc   <= '0;
                    r_ss    <= '0;
                    r_sat   <= 1'b0;
                end
                pnu_pkg::S_DOT: if (fetch) r_i <= r_i + CW'(1);
                pnu_pkg::S_PRED: begin
                    r_pred <= (r_acc >= 0);
                    r_rem  <= '0;
                    r_root <= '0;
                    r_sk   <= 6'd32;
                    r_s    <= s_src;
                    r_pi   <= '0;
                    r_i    <= '0;
                end
                pnu_pkg::S_SQRT: begin
                    if (r_sk != 6'd0) begin
                        if (srem_sh >= 64'(stry)) begin
                            r_rem  <= 62'(srem_sh - 64'(stry));
                            r_root <= {r_root[RW-2:0], 1'b1};
                        end else begin
                            r_rem  <= srem_sh[61:0];
                            r_root <= {r_root[RW-2:0], 1'b0};
                        end
                        r_s  <= {r_s[61:0], 2'b00};
                        r_sk <= r_sk - 6'd1;
                    end
                    r_i <= '0;
                end
                pnu_pkg::S_DIVLD: begin
                    // numerator |x|*2^30 + r/2, 48 bits
                    r_num  <= ({31'b0, (i_rd_data < 0) ? 17'(-i_rd_data)
                                                    : 17'(i_rd_data)} << 30)
                              + 48'(r_root >> 1);
                    r_neg  <= i_rd_data < 0;
                    r_drem <= '0;
                    r_q    <= '0;
                    r_dk   <= 6'd48;
                    // next element address, so its data is ready at the next load
                    r_i    <= r_pi + CW'(1);
                end
                pnu_pkg::S_DIV: begin
                    if (r_dk != 6'd0) begin
                        if (!rtrial[RW+1]) begin
                            r_drem <= rtrial[RW-1:0];
                            r_q    <= {r_q[46:0], 1'b1};
                        end else begin
                            r_drem <= dtrial[RW-1:0];
                            r_q    <= {r_q[46:0], 1'b0};
                        end
                        r_num <= {r_num[46:0], 1'b0};
                        r_dk  <= r_dk - 6'd1;
                    end
                end
                pnu_pkg::S_UPD: begin
                    if (wsum > 34'sd2147483647) begin
                        r_w[widx] <= 32'sh7fffffff;
                        r_sat     <= 1'b1;
                    end else if (wsum < -34'sd2147483648) begin
                        r_w[widx] <= 32'sh80000000;
                        r_sat     <= 1'b1;
                    end else begin
                        r_w[widx] <= wsum[31:0];
                    end
                    r_pi <= r_pi + CW'(1);
                end
                pnu_pkg::S_OUT: begin
                    if (!r_ov) begin
                        r_ov    <= 1'b1;
                        r_opred <= r_pred;
                        r_oupd  <= r_learn && (r_pred != r_label) && (r_ss != '0);
                        r_osat  <= r_sat;
                    end
                end
                default: ;
            endcase
            // products land in the cycle after the read data
            if (r_pv2) begin
                r_acc <= r_acc + AW'(r_prod);
                r_ss  <= r_ss + SW'(r_sq);
            end
        end
    end

    // product stage for the dot loop (data is read in the cycle after fetch)
    always_ff @(posedge i_clk) begin
        r_prod <= 48'(r_w[r_pi_d[IW-1:0]]) * 48'(i_rd_data);
        r_sq   <= 32'($signed(i_rd_data) * $signed(i_rd_data));
    end

    always_ff @(posedge i_clk) r_pi_d <= r_i;

    assign o_empty      = !r_ov;
    assign o_prediction = r_opred;
    assign o_updated    = r_oupd;
    assign o_saturated  = r_osat;
endmodule
`default_nettype wire

FILE: rtl/perceptron_normalized_update_unit.sv
// Top level of the normalized perceptron update unit.
//
// channel | direction | handshake    | word
// input   | in        | push / full  | req_type, feature, label, last
// result  | out       | pop / empty  | prediction, updated, saturated
//
// An element is taken each cycle while full is low. A closing element
// hands the vector to the back end, which forms the dot product of the
// held elements and, on a learn that changes weights, takes the root and
// then divides and updates each element. Two vector buffers let the next
// vector load meanwhile; full stays high while both wait; the back end holds
// a new result while one waits. Reset is synchronous, clears weights and queues.
`default_nettype none
module perceptron_normalized_update_unit #(
    parameter int DIM = pnu_pkg::DIM_DEFAULT
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic               i_req_type,
    input  wire logic signed [15:0] i_feature,
    input  wire logic               i_label,
    input  wire logic               i_last,
    output logic                    empty,
    input  wire logic               pop,
    output logic                    o_prediction,
    output logic                    o_updated,
    output logic                    o_saturated
);
    localparam int CW = $clog2(DIM+1);
    localparam int IW = ($clog2(DIM) > 0) ? $clog2(DIM) : 1;

    logic               job_valid, job_bank, job_done, rd_bank;
    pnu_pkg::t_job      job;
    logic [CW-1:0]      job_n;
    logic [IW-1:0]      rd_idx;
    logic signed [15:0] rd_data;

    pnu_front #(.DIM(DIM)) u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full),
        .i_req_type, .i_feature, .i_label, .i_last,
        .o_job_valid(job_valid), .o_job(job), .o_job_n(job_n),
        .o_job_bank(job_bank), .i_job_done(job_done),
        .i_rd_idx(rd_idx), .i_rd_bank(rd_bank), .o_rd_data(rd_data)
    );

    pnu_back #(.DIM(DIM)) u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(job_valid), .i_job(job), .i_job_n(job_n),
        .i_job_bank(job_bank), .o_job_done(job_done),
        .o_rd_idx(rd_idx), .o_rd_bank(rd_bank), .i_rd_data(rd_data),
        .o_empty(empty), .i_pop(pop),
        .o_prediction, .o_updated, .o_saturated
    );
endmodule
`default_nettype wire

FILE: tb/perceptron_normalized_update_unit_tb.sv
// Self-checking testbench of the normalized perceptron update unit.
`default_nettype none
module perceptron_normalized_update_unit_tb;

    localparam int NDIM      = pnu_pkg::DIM_DEFAULT;
    localparam int LIMIT     = 400000;
    localparam int HOLD_LEN  = 400;
    localparam bit REQ_CLASSIFY = 1'b0;
    localparam bit REQ_LEARN    = 1'b1;
    localparam int KIND_RANDOM  = 0;
    localparam int KIND_ZERO    = 1;
    localparam int KIND_MAX     = 2;
    localparam int KIND_MIN     = 3;

    typedef struct {
        bit                      req;
        logic signed [pnu_pkg::FEAT_W-1:0] feature;
        bit                      label;
        bit                      last;
        bit                      drain;  // sender waits for all results first
    } t_elem;

    typedef struct {
        bit pred;
        bit upd;
        bit sat;
    } t_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic i_req_type = 1'b0;
    logic signed [15:0] i_feature = '0;
    logic i_label = 1'b0;
    logic i_last = 1'b0;
    logic full, empty, o_prediction, o_updated, o_saturated;

    perceptron_normalized_update_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full),
        .i_req_type(i_req_type), .i_feature(i_feature),
        .i_label(i_label), .i_last(i_last),
        .empty(empty), .pop(pop),
        .o_prediction(o_prediction), .o_updated(o_updated), .o_saturated(o_saturated)
    );

    always #6 i_clk = ~i_clk;

    t_elem    pending_words[$];
    t_verdict expected_verdicts[$];
    longint   wgt[NDIM];
    longint   vbuf[NDIM];
    int       n_held = 0;
    int       n_sent = 0;
    int       cycles = 0;
    bit       failed = 1'b0;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // classify / learn on a vector word; queues a verdict on the closing one
    function automatic void absorb_word(t_elem e);
        longint acc = 0;
        longint unsigned sumsq = 0;
        longint unsigned r, q, mag;
        longint ni, w;
        int n;
        t_verdict v;
        if (n_held < NDIM) begin
            vbuf[n_held] = longint'(e.feature);
            n_held++;
        end
        if (!e.last) return;
        n = n_held;
        n_held = 0;
        for (int i = 0; i < n; i++) begin
            acc += wgt[i] * vbuf[i];
            sumsq += longint'(vbuf[i] * vbuf[i]);
        end
        v.pred = (acc >= 0);
        v.upd = 0;
        v.sat = 0;
        if (e.req == REQ_LEARN && v.pred != e.label && sumsq != 0) begin
            r = int_sqrt(sumsq << 28);
            v.upd = 1;
            for (int i = 0; i < n; i++) begin
                mag = (vbuf[i] < 0) ? -vbuf[i] : vbuf[i];
                q = ((mag << 30) + (r >> 1)) / r;
                if (q > 65536) q = 65536;
                ni = (vbuf[i] < 0) ? -longint'(q) : longint'(q);
                w = e.label ? wgt[i] + ni : wgt[i] - ni;
                if (w > 64'sd2147483647) begin
                    w = 64'sd2147483647;
                    v.sat = 1;
                end else if (w < -64'sd2147483648) begin
                    w = -64'sd2147483648;
                    v.sat = 1;
                end
                wgt[i] = w;
            end
        end
        expected_verdicts.push_back(v);
    endfunction

    function automatic int rand_gap();
        int p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic add_vector(int len, bit req, bit label, int kind, bit drain);
        t_elem e;
        for (int i = 0; i < len; i++) begin
            e.req = (i == len - 1) ? req : 1'($urandom);
            e.label = (i == len - 1) ? label : 1'($urandom);
            e.last = (i == len - 1);
            e.drain = drain && (i == 0);
            case (kind)
                KIND_ZERO: e.feature = '0;
                KIND_MAX: e.feature = 16'sh7FFF;
                KIND_MIN: e.feature = -16'sh8000;
                default: begin
                    case ($urandom_range(0, 9))
                        0: e.feature = 16'sh7FFF;
                        1: e.feature = -16'sh8000;
                        2: e.feature = 16'($urandom_range(0, 64)) - 16'sd32;
                        default: e.feature = 16'($urandom);
                    endcase
                end
            endcase
            pending_words.push_back(e);
        end
    endtask

    // driver
    int gap_left = 0;
    int burst_left = 0;
    always @(posedge i_clk) begin
        t_elem e;
        bit take;
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            take = push && !full;
            if (take) begin
                absorb_word('{i_req_type, i_feature, i_label, i_last, 1'b0});
                n_sent++;
            end
            if (push && !take) begin
                // hold the word until accepted
            end else if (gap_left > 0) begin
                gap_left--;
                push <= 1'b0;
            end else if (pending_words.size() != 0 &&
                         !(pending_words[0].drain && expected_verdicts.size() != 0)) begin
                e = pending_words.pop_front();
                push <= 1'b1;
                i_req_type <= e.req;
                i_feature <= e.feature;
                i_label <= e.label;
                i_last <= e.last;
                if (burst_left > 0) burst_left--;
                else if ($urandom_range(0, 49) == 0) burst_left = 30;
                else gap_left = rand_gap();
            end else begin
                push <= 1'b0;
            end
        end
    end

    // monitor
    int stall_left = 0;
    bit held_once = 1'b0;
    always @(posedge i_clk) begin
        t_verdict v;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_verdicts.size() == 0) begin
                    $display("%0t: unexpected word pred=%0d upd=%0d sat=%0d", $time,
                             o_prediction, o_updated, o_saturated);
                    failed = 1'b1;
                end else begin
                    v = expected_verdicts.pop_front();
                    if (o_prediction !== v.pred) begin
                        $display("%0t: prediction expected %0d actual %0d", $time,
                                 v.pred, o_prediction);
                        failed = 1'b1;
                    end
                    if (o_updated !== v.upd) begin
                        $display("%0t: updated expected %0d actual %0d", $time,
                                 v.upd, o_updated);
                        failed = 1'b1;
                    end
                    if (o_saturated !== v.sat) begin
                        $display("%0t: saturated expected %0d actual %0d", $time,
                                 v.sat, o_saturated);
                        failed = 1'b1;
                    end
                end
            end
            if (!held_once && n_sent >= 60) begin
                // long hold-off so the input side fills and stalls
                held_once = 1'b1;
                stall_left = HOLD_LEN;
                pop <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else begin
                stall_left = rand_gap();
                pop <= (stall_left == 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > LIMIT) begin
            $display("perceptron_normalized_update_unit test failed");
            $finish;
        end
    end

    initial begin
        int len;
        for (int i = 0; i < NDIM; i++) wgt[i] = 0;
        // directed: extremes, zero vector, classify, short and long vectors
        add_vector(1, REQ_LEARN, 1'b0, KIND_MAX, 1'b0);
        add_vector(1, REQ_LEARN, 1'b1, KIND_MIN, 1'b0);
        add_vector(2, REQ_LEARN, 1'b0, KIND_ZERO, 1'b0);
        add_vector(3, REQ_CLASSIFY, 1'b0, KIND_MIN, 1'b0);
        add_vector(2, REQ_LEARN, 1'b1, KIND_MAX, 1'b0);
        add_vector(NDIM + 2, REQ_LEARN, 1'b1, KIND_RANDOM, 1'b0);
        add_vector(3, REQ_LEARN, 1'b0, KIND_RANDOM, 1'b0);
        while (pending_words.size() < 520) begin
            case ($urandom_range(0, 9))
                0: len = $urandom_range(NDIM + 1, NDIM + 3);
                1, 2: len = $urandom_range(1, 3);
                default: len = NDIM;
            endcase
            add_vector(len, ($urandom_range(0, 9) < 7) ? REQ_LEARN : REQ_CLASSIFY,
                       1'($urandom),
                       ($urandom_range(0, 19) == 0) ? KIND_ZERO : KIND_RANDOM,
                       pending_words.size() > 250 && pending_words.size() < 262);
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_words.size() == 0 && !push);
        wait (expected_verdicts.size() == 0);
        repeat (600) @(posedge i_clk);
        if (!failed)
            $display("perceptron_normalized_update_unit test passed");
        else
            $display("perceptron_normalized_update_unit test failed");
        $finish;
    end
endmodule
`default_nettype wire
